### src/rlbd_pkg.sv
// ----------------------------------------------------------------------------
// rlbd_pkg
// Shared widths, reset values, register indexes and types for the
// resistor-ladder button decoder.
// ----------------------------------------------------------------------------
package rlbd_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int BTN_W        = 2;
  localparam int CNT_W        = 8;
  localparam int BCNT_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 12;

  // threshold registers provided by the register map
  localparam int THRESH_REGS  = 4;
  localparam int NUM_BUTTONS  = 4;

  localparam logic [SAMPLE_W-1:0] LOW_BOUND_RST    = 12'd0;
  localparam logic [SAMPLE_W-1:0] HIGH_BOUND_RST   = 12'd4000;
  localparam logic [CNT_W-1:0]    READ_NUMBER_RST  = 8'd3;
  localparam logic [BCNT_W-1:0]   BUTTON_COUNT_RST = 3'd4;
  localparam logic [CNT_W-1:0]    CNT_MAX          = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_BOUND    = 3'd0,
    CFG_HIGH_BOUND   = 3'd1,
    CFG_READ_NUMBER  = 3'd2,
    CFG_BUTTON_COUNT = 3'd3,
    CFG_THRESH_0     = 3'd4,
    CFG_THRESH_1     = 3'd5,
    CFG_THRESH_2     = 3'd6,
    CFG_THRESH_3     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic             hit;
    logic [BTN_W-1:0] idx;
  } match_t;

endpackage

### src/rlbd_if.sv
// ----------------------------------------------------------------------------
// rlbd_if
// Valid/ready channels of the button decoder: sample words in, event words out.
// ----------------------------------------------------------------------------
interface rlbd_in_if;
  import rlbd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rlbd_out_if;
  import rlbd_pkg::*;

  logic                valid;
  logic                ready;
  logic                is_press;
  logic [BTN_W-1:0]    button;
  logic [SAMPLE_W-1:0] level;

  modport source (output valid, output is_press, output button, output level, input ready);
  modport sink   (input valid, input is_press, input button, input level, output ready);
endinterface

### src/resistor_ladder_button_decoder.sv
// ----------------------------------------------------------------------------
// resistor_ladder_button_decoder
// Debounces ADC samples of a resistor-ladder line into press/release events.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one 12-bit ADC sample per word (valid/ready).
//   out_ch : zero or one event word per sample: is_press, button, level.
//   cfg_*  : write-only register port, index 0..7 as in the register map;
//            write only while no sample is in flight.
// Timing: a sample is captured in an input register, decoded against the
//   thresholds in one pass and its event lands in the output register, so
//   out_ch.valid rises once the decoded sample is registered there. One sample
//   is accepted every cycle while out_ch.ready does not hold the output; the
//   rate is set by the single decode stage.
// Stall: while an event waits in the output register and out_ch.ready is
//   low, the decode stage holds and in_ch.ready drops once the input
//   register is also full; nothing is lost or repeated.
// Reset: rst_n (synchronous) clears the pipeline, the held button and the
//   candidate, and returns the registers to their defaults (thresholds 0,
//   i.e. all buttons disabled).
// ----------------------------------------------------------------------------
module resistor_ladder_button_decoder #(
  parameter int NUM_BUTTONS = rlbd_pkg::NUM_BUTTONS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rlbd_in_if.sink                           in_ch,
  rlbd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [rlbd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [rlbd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rlbd_pkg::*;

  localparam int NUM_THR = (NUM_BUTTONS < THRESH_REGS) ? NUM_BUTTONS : THRESH_REGS;

  // configuration
  logic [SAMPLE_W-1:0]              low_bound_r;
  logic [SAMPLE_W-1:0]              high_bound_r;
  logic [CNT_W-1:0]                 read_number_r;
  logic [BCNT_W-1:0]                button_count_r;
  logic [NUM_THR-1:0][SAMPLE_W-1:0] thresh_r;

  // decoder state
  logic             held_v_r, held_v_nxt;
  logic [BTN_W-1:0] held_btn_r, held_btn_nxt;
  logic [SAMPLE_W-1:0] level_r, level_nxt;
  logic             cand_v_r, cand_v_nxt;
  logic [BTN_W-1:0] cand_btn_r, cand_btn_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // pipeline
  logic                s1_v_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                out_v_r;
  logic                out_press_r, out_press_nxt;
  logic [BTN_W-1:0]    out_btn_r, out_btn_nxt;
  logic [SAMPLE_W-1:0] out_level_r, out_level_nxt;

  logic       advance;
  logic       proc;
  logic       res_load;
  logic       in_fire;
  match_t     match;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] need;

  assign advance  = !out_v_r || out_ch.ready;
  assign proc     = s1_v_r && advance;
  assign in_ch.ready = !s1_v_r || advance;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign out_ch.valid    = out_v_r;
  assign out_ch.is_press = out_press_r;
  assign out_ch.button   = out_btn_r;
  assign out_ch.level    = out_level_r;

  rlbd_match #(
    .NUM_THR (NUM_THR)
  ) u_match (
    .sample       (s1_sample_r),
    .thresh       (thresh_r),
    .button_count (button_count_r),
    .match        (match)
  );

  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign need    = (read_number_r == '0) ? CNT_W'(1) : read_number_r;

  always_comb begin
    held_v_nxt    = held_v_r;
    held_btn_nxt  = held_btn_r;
    level_nxt     = level_r;
    cand_v_nxt    = cand_v_r;
    cand_btn_nxt  = cand_btn_r;
    cnt_nxt       = cnt_r;
    res_load      = 1'b0;
    out_press_nxt = 1'b0;
    out_btn_nxt   = held_btn_r;
    out_level_nxt = level_r;

    if (proc && (s1_sample_r >= low_bound_r)) begin
      if (s1_sample_r >= high_bound_r) begin
        // release
        res_load     = held_v_r;
        held_v_nxt   = 1'b0;
        held_btn_nxt = '0;
        cand_v_nxt   = 1'b0;
        cand_btn_nxt = '0;
        cnt_nxt      = '0;
      end else if (!held_v_r && match.hit) begin
        level_nxt    = s1_sample_r;
        cand_v_nxt   = 1'b1;
        cand_btn_nxt = match.idx;
        if (cand_v_r && cand_btn_r == match.idx) begin
          cnt_nxt = cnt_inc;
        end else begin
          cnt_nxt = CNT_W'(1);
        end
        if (cnt_nxt >= need) begin
          held_v_nxt    = 1'b1;
          held_btn_nxt  = match.idx;
          res_load      = 1'b1;
          out_press_nxt = 1'b1;
          out_btn_nxt   = match.idx;
          out_level_nxt = s1_sample_r;
        end
      end else begin
        if (!held_v_r) begin
          level_nxt = s1_sample_r;
        end
        cand_v_nxt   = 1'b0;
        cand_btn_nxt = '0;
        cnt_nxt      = '0;
      end
    end

    // new button count drops the held button silently
    if (cfg_we && cfg_idx == CFG_BUTTON_COUNT) begin
      held_v_nxt   = 1'b0;
      held_btn_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_bound_r    <= LOW_BOUND_RST;
      high_bound_r   <= HIGH_BOUND_RST;
      read_number_r  <= READ_NUMBER_RST;
      button_count_r <= BUTTON_COUNT_RST;
      thresh_r       <= '0;
      held_v_r       <= 1'b0;
      held_btn_r     <= '0;
      level_r        <= '0;
      cand_v_r       <= 1'b0;
      cand_btn_r     <= '0;
      cnt_r          <= '0;
      s1_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
    end else begin
      level_r    <= level_nxt;
      cand_v_r   <= cand_v_nxt;
      cand_btn_r <= cand_btn_nxt;
      cnt_r      <= cnt_nxt;
      held_v_r   <= held_v_nxt;
      held_btn_r <= held_btn_nxt;

      if (cfg_we) begin
        case (cfg_idx)
          CFG_LOW_BOUND:    low_bound_r    <= cfg_wdata;
          CFG_HIGH_BOUND:   high_bound_r   <= cfg_wdata;
          CFG_READ_NUMBER:  read_number_r  <= cfg_wdata[CNT_W-1:0];
          CFG_BUTTON_COUNT: button_count_r <= cfg_wdata[BCNT_W-1:0];
          default: ;
        endcase
        for (int k = 0; k < NUM_THR; k++) begin
          if (cfg_idx == CFG_IDX_W'(CFG_THRESH_0 + k)) begin
            thresh_r[k] <= cfg_wdata;
          end
        end
      end

      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end

      if (advance) begin
        out_v_r <= res_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_ch.sample;
    end
    if (res_load) begin
      out_press_r <= out_press_nxt;
      out_btn_r   <= out_btn_nxt;
      out_level_r <= out_level_nxt;
    end
  end

`ifndef ASSERT_OFF
  // match counter is non-zero exactly while a candidate exists
  a_cnt_cand: assert property (@(posedge clk) disable iff (!rst_n)
    cand_v_r == (cnt_r != '0))
    else $error("match counter out of step with candidate");

  // a press event leaves that button held
  a_press_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && out_press_nxt && !cfg_we) |=> (held_v_r && held_btn_r == out_btn_r))
    else $error("press without held button");

  // a release event leaves nothing held
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && !out_press_nxt) |=> !held_v_r)
    else $error("release left a button held");

  // with the output slot free the input is never blocked
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ch.ready)
    else $error("input stalled with empty output");
`endif

endmodule

### src/rlbd_match.sv
// ----------------------------------------------------------------------------
// rlbd_match
// Parallel threshold compare with priority pick: first enabled button whose
// threshold the sample does not exceed.
// ----------------------------------------------------------------------------
module rlbd_match #(
  parameter int NUM_THR = 4
) (
  input  logic [rlbd_pkg::SAMPLE_W-1:0]              sample,
  input  logic [NUM_THR-1:0][rlbd_pkg::SAMPLE_W-1:0] thresh,
  input  logic [rlbd_pkg::BCNT_W-1:0]                button_count,
  output rlbd_pkg::match_t                           match
);
  import rlbd_pkg::*;

  logic [NUM_THR-1:0] hit_vec;

  always_comb begin
    for (int i = 0; i < NUM_THR; i++) begin
      hit_vec[i] = (BCNT_W'(i) < button_count) && (thresh[i] != '0) &&
                   (sample <= thresh[i]);
    end
  end

  // walk downwards so the lowest index wins
  always_comb begin
    match = '0;
    for (int i = NUM_THR - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        match.hit = 1'b1;
        match.idx = BTN_W'(i);
      end
    end
  end

endmodule

### bench/tb_resistor_ladder_button_decoder.sv
// ----------------------------------------------------------------------------
// tb_resistor_ladder_button_decoder
// Self-checking bench for the ladder button decoder. Sample words are fed
// through the input channel with random gaps. Each accepted sample runs
// through a local debounce predictor, and the press/release words it
// predicts are queued. Every event word that leaves the block is compared
// with the oldest queued prediction. Directed cases come first, among them
// a long sink hold-off and a full-length debounce count, then randomised
// press/release sequences under several register settings.
// ----------------------------------------------------------------------------
module tb_resistor_ladder_button_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import rlbd_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic                is_press;
    logic [BTN_W-1:0]    button;
    logic [SAMPLE_W-1:0] level;
  } ladder_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rlbd_in_if  in_ch ();
  rlbd_out_if out_ch ();

  resistor_ladder_button_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [SAMPLE_W-1:0] lo_bound;
  logic [SAMPLE_W-1:0] hi_bound;
  logic [CNT_W-1:0]    presses_needed;
  logic [BCNT_W-1:0]   btn_limit;
  logic [SAMPLE_W-1:0] thresh [THRESH_REGS];

  // predictor copy of the debounce state
  logic                btn_held;
  logic [BTN_W-1:0]    held_idx;
  logic [SAMPLE_W-1:0] level_q;
  logic                cand_on;
  logic [BTN_W-1:0]    cand_idx;
  logic [CNT_W-1:0]    hit_count;

  ladder_event_t expected_events [$];
  int  fault_count = 0;
  int  items_sent = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  // bumped by the test side for each long sink hold-off
  int  hold_reqs = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic match_t ladder_lookup(input logic [SAMPLE_W-1:0] s);
    match_t m;
    int     span;
    m = '0;
    span = int'(btn_limit);
    if (span > NUM_BUTTONS) span = NUM_BUTTONS;
    if (span > THRESH_REGS) span = THRESH_REGS;
    for (int i = 0; i < span; i++) begin
      if (thresh[i] != 0 && s <= thresh[i]) begin
        m.hit = 1'b1;
        m.idx = i[BTN_W-1:0];
        return m;
      end
    end
    return m;
  endfunction

  function automatic void clear_ladder();
    lo_bound       = LOW_BOUND_RST;
    hi_bound       = HIGH_BOUND_RST;
    presses_needed = READ_NUMBER_RST;
    btn_limit      = BUTTON_COUNT_RST;
    foreach (thresh[i]) thresh[i] = '0;
    btn_held  = 1'b0;
    held_idx  = '0;
    level_q   = '0;
    cand_on   = 1'b0;
    cand_idx  = '0;
    hit_count = '0;
  endfunction

  function automatic void apply_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_LOW_BOUND:   lo_bound = val;
      CFG_HIGH_BOUND:  hi_bound = val;
      CFG_READ_NUMBER: presses_needed = val[CNT_W-1:0];
      CFG_BUTTON_COUNT: begin
        // held button goes silently
        btn_limit = val[BCNT_W-1:0];
        btn_held  = 1'b0;
        held_idx  = '0;
      end
      default: thresh[int'(idx) - int'(CFG_THRESH_0)] = val;
    endcase
  endfunction

  function automatic void take_sample(input logic [SAMPLE_W-1:0] s);
    match_t        m;
    logic [CNT_W-1:0] need;
    ladder_event_t ev;
    if (s < lo_bound) return;
    if (s >= hi_bound) begin
      if (btn_held) begin
        ev.is_press = 1'b0;
        ev.button   = held_idx;
        ev.level    = level_q;
        expected_events.push_back(ev);
      end
      btn_held  = 1'b0;
      held_idx  = '0;
      cand_on   = 1'b0;
      cand_idx  = '0;
      hit_count = '0;
      return;
    end
    if (!btn_held) begin
      level_q = s;
      m = ladder_lookup(s);
      if (m.hit) begin
        if (cand_on && cand_idx == m.idx) begin
          if (hit_count != CNT_MAX) hit_count++;
        end else begin
          cand_on   = 1'b1;
          cand_idx  = m.idx;
          hit_count = 8'd1;
        end
        need = (presses_needed == 0) ? 8'd1 : presses_needed;
        if (hit_count >= need) begin
          btn_held    = 1'b1;
          held_idx    = m.idx;
          ev.is_press = 1'b1;
          ev.button   = m.idx;
          ev.level    = s;
          expected_events.push_back(ev);
        end
        return;
      end
    end
    cand_on   = 1'b0;
    cand_idx  = '0;
    hit_count = '0;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    take_sample(s);
    items_sent++;
  endtask

  // drop valid and let every outstanding event word drain
  task automatic settle_decoder();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic program_ladder(input logic [CFG_DATA_W-1:0] lo, hi, need, count,
                                t0, t1, t2, t3);
    settle_decoder();
    write_reg(CFG_LOW_BOUND, lo);
    write_reg(CFG_HIGH_BOUND, hi);
    write_reg(CFG_READ_NUMBER, need);
    write_reg(CFG_BUTTON_COUNT, count);
    write_reg(CFG_THRESH_0, t0);
    write_reg(CFG_THRESH_1, t1);
    write_reg(CFG_THRESH_2, t2);
    write_reg(CFG_THRESH_3, t3);
  endtask

  // a debounced press with jitter, then optional held samples and a release;
  // some runs are cut short or are plain noise
  task automatic play_press_sequence();
    int     kind, reps, lo, hi, s_i;
    bit     found;
    logic [SAMPLE_W-1:0] base;
    match_t m, m2;
    kind  = $urandom_range(0, 9);
    lo    = int'(lo_bound);
    hi    = int'(hi_bound);
    found = 1'b0;
    base  = '0;
    m     = '0;
    if (kind < 8 && lo < hi) begin
      for (int t = 0; t < 8 && !found; t++) begin
        base = SAMPLE_W'($urandom_range(lo, hi - 1));
        m = ladder_lookup(base);
        found = m.hit;
      end
    end
    if (!found) begin
      repeat ($urandom_range(1, 4)) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
      return;
    end
    reps = (presses_needed == 0) ? 1 : int'(presses_needed);
    if (kind == 7) reps = $urandom_range(1, reps);
    else reps = reps - 1 + $urandom_range(0, 2);
    if (reps < 1) reps = 1;
    for (int r = 0; r < reps; r++) begin
      if (lo > 0 && $urandom_range(0, 7) == 0)
        send_sample(SAMPLE_W'($urandom_range(0, lo - 1)));
      s_i = int'(base) + int'($urandom_range(0, 6)) - 3;
      if (s_i < lo || s_i >= hi) s_i = int'(base);
      else begin
        m2 = ladder_lookup(s_i[SAMPLE_W-1:0]);
        if (m2 != m) s_i = int'(base);
      end
      send_sample(s_i[SAMPLE_W-1:0]);
    end
    // broken run: something else in the window
    if (kind == 7) send_sample(SAMPLE_W'($urandom_range(lo, hi - 1)));
    if ($urandom_range(0, 1) == 0)
      repeat ($urandom_range(1, 2)) send_sample(SAMPLE_W'($urandom_range(lo, hi - 1)));
    if ($urandom_range(0, 4) != 0) send_sample(SAMPLE_W'($urandom_range(hi, 4095)));
  endtask

  // --------------------------------------------------------------------------
  // Sink: random stalls, steady stretches and the long hold-off
  // --------------------------------------------------------------------------
  initial begin : event_sink
    int stall_left;
    int r;
    int hold_seen;
    stall_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        stall_left = HOLD_CYCLES;
        hold_seen = hold_reqs;
      end else if (stall_left == 0 && !rx_steady && $urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 70) stall_left = $urandom_range(1, 2);
        else if (r < 95) stall_left = $urandom_range(3, 8);
        else stall_left = $urandom_range(10, 40);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_events
    ladder_event_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event word: is_press %0d button %0d level %0d",
               out_ch.is_press, out_ch.button, out_ch.level);
        fault_count++;
      end else begin
        want = expected_events.pop_front();
        if (out_ch.is_press !== want.is_press) begin
          $error("is_press: expected %0d, got %0d", want.is_press, out_ch.is_press);
          fault_count++;
        end
        if (out_ch.button !== want.button) begin
          $error("button: expected %0d, got %0d", want.button, out_ch.button);
          fault_count++;
        end
        if (out_ch.level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, out_ch.level);
          fault_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // all buttons disabled out of reset, default high bound 4000
  task automatic test_reset_defaults();
    send_sample(12'd0);
    send_sample(12'd3999);
    send_sample(12'd4000);
    send_sample(12'd4095);
  endtask

  task automatic test_press_release();
    logic [SAMPLE_W-1:0] walk [13] = '{
      12'd800, 12'd50, 12'd700, 12'd800,    // below-low word keeps the count
      12'd2000, 12'd3500, 12'd3500,         // held in window, release, idle release
      12'd3300,                             // in window, nothing matches
      12'd1600, 12'd1601, 12'd1601, 12'd1601, // candidate swaps button
      12'd4095
    };
    program_ladder(12'd100, 12'd3500, 12'd3, 12'd4,
                   12'd800, 12'd1600, 12'd2400, 12'd3200);
    foreach (walk[i]) send_sample(walk[i]);
  endtask

  task automatic test_edge_settings();
    program_ladder(12'd0, 12'd4095, 12'd1, 12'd4, 12'd0, 12'd1000, 12'd0, 12'd4095);
    send_sample(12'd0);
    settle_decoder();
    write_reg(CFG_BUTTON_COUNT, 12'd0);
    send_sample(12'd4095);
    send_sample(12'd500);
    settle_decoder();
    write_reg(CFG_READ_NUMBER, 12'd0);
    write_reg(CFG_BUTTON_COUNT, 12'd7);
    send_sample(12'd4094);
    settle_decoder();
    // crossed bounds: anything not ignored counts as a release
    write_reg(CFG_LOW_BOUND, 12'd3000);
    write_reg(CFG_HIGH_BOUND, 12'd1000);
    send_sample(12'd2999);
    send_sample(12'd3000);
    send_sample(12'd4095);
    settle_decoder();
    write_reg(CFG_LOW_BOUND, 12'd0);
    write_reg(CFG_HIGH_BOUND, 12'd0);
    send_sample(12'd0);
  endtask

  // full 255-word debounce, counter at its ceiling
  task automatic test_slow_debounce();
    program_ladder(12'd0, 12'd4095, 12'hFFF, 12'hFFF, 12'd4095, 12'd0, 12'd0, 12'd0);
    repeat (255) send_sample(SAMPLE_W'($urandom_range(0, 4094)));
    send_sample(SAMPLE_W'($urandom_range(0, 4094)));
    send_sample(12'd4095);
  endtask

  task automatic test_back_pressure();
    program_ladder(12'd0, 12'd4000, 12'd1, 12'd4,
                   12'd1000, 12'd2000, 12'd3000, 12'd3900);
    tx_steady = 1'b1;
    hold_reqs++;
    repeat (20) begin
      send_sample(SAMPLE_W'($urandom_range(0, 3900)));
      send_sample(SAMPLE_W'($urandom_range(4000, 4095)));
    end
    settle_decoder();
    tx_steady = 1'b0;
  endtask

  task automatic test_random_ladder(input int n_phases, input int per_phase);
    int tv [THRESH_REGS];
    int first;
    for (int ph = 0; ph < n_phases; ph++) begin
      if (ph == 0) begin
        program_ladder(12'd0, 12'd4095, 12'd1, 12'd7, 12'd1, 12'd2048, 12'd4094, 12'd4095);
      end else begin
        for (int i = 0; i < THRESH_REGS; i++)
          tv[i] = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(i * 800 + 1, i * 800 + 800);
        if ($urandom_range(0, 3) == 0)
          foreach (tv[i]) tv[i] = $urandom_range(0, 4095);
        program_ladder(
          CFG_DATA_W'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 500)),
          CFG_DATA_W'(($urandom_range(0, 1) == 0) ? 4095 : $urandom_range(3200, 4095)),
          CFG_DATA_W'($urandom_range(0, 5)),
          CFG_DATA_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 4),
          CFG_DATA_W'(tv[0]), CFG_DATA_W'(tv[1]), CFG_DATA_W'(tv[2]), CFG_DATA_W'(tv[3]));
      end
      tx_steady = ($urandom_range(0, 2) == 0);
      rx_steady = ($urandom_range(0, 2) == 0);
      first = items_sent;
      while (items_sent - first < per_phase) play_press_sequence();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    clear_ladder();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_press_release();
    test_edge_settings();
    test_back_pressure();
    test_slow_debounce();
    test_random_ladder(6, 18);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
